// ===== rtl/bsiu_pkg.sv =====
// ----------------------------------------------------------------------------
// bsiu_pkg
// Shared types and constants for the bounded set intersect/union block.
// ----------------------------------------------------------------------------
package bsiu_pkg;

  localparam int SET_DEPTH = 32;
  localparam int SCR_DEPTH = 2 * SET_DEPTH;
  localparam int CNT_W     = $clog2(SET_DEPTH + 1);
  localparam int STEP_W    = (SET_DEPTH > 1) ? $clog2(SET_DEPTH) : 1;
  localparam int FILL_W    = $clog2(SCR_DEPTH + 1);

  localparam logic [2:0] CMD_INSERT   = 3'd0;
  localparam logic [2:0] CMD_CONTAINS = 3'd1;
  localparam logic [2:0] CMD_ISECT    = 3'd2;
  localparam logic [2:0] CMD_UNION    = 3'd3;
  localparam logic [2:0] CMD_CLEAR    = 3'd4;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK_A,
    ST_WALK_B,
    ST_FLUSH
  } state_t;

  typedef struct packed {
    logic [2:0]         command;
    logic               which_set;
    logic signed [31:0] value;
  } req_t;

  typedef struct packed {
    logic signed [31:0] element;
    logic               has_element;
    logic               found;
    logic               status;
    logic               last;
  } rsp_t;

endpackage

// ===== rtl/bsiu_cell.sv =====
// ----------------------------------------------------------------------------
// bsiu_cell
// One storage cell of a chain: loads from its neighbor and compares to a key.
// ----------------------------------------------------------------------------
module bsiu_cell (
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] din,
  input  logic [31:0] key,
  output logic [31:0] q,
  output logic        eq
);

  // payload register, no reset
  always_ff @(posedge clk) begin
    if (en) begin
      q <= din;
    end
  end

  assign eq = (q == key);

endmodule

// ===== rtl/bounded_set_intersect_union.sv =====
// Insert, contains, clear and unknown codes give one result beat in the cycle
//   after start; a new command may start every cycle after these.
// Intersection walks store A, union walks A then B; a flush state follows,
//   then the final beat, as busy drops.
// Results are one-cycle strobes; the receiver cannot stall.
// Reset (rst, synchronous) empties both stores and returns to idle.
// ----------------------------------------------------------------------------
// bounded_set_intersect_union
// Two chains of value cells (A, B) and a scratch chain of emitted values.
// ----------------------------------------------------------------------------
module bounded_set_intersect_union (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  bsiu_pkg::req_t req,
  output logic          strobe,
  output bsiu_pkg::rsp_t rsp
);
  import bsiu_pkg::*;

  state_t state, state_next;
  logic [CNT_W-1:0]  count_a, count_b;
  logic [STEP_W-1:0] step;
  logic [FILL_W-1:0] fill;
  logic              op_isect, op_union;
  logic              pend_valid;
  logic [31:0]       pend;

  logic [31:0] a_q [SET_DEPTH];
  logic [31:0] b_q [SET_DEPTH];
  logic [31:0] s_q [SCR_DEPTH];
  logic [SET_DEPTH-1:0] a_eq, b_eq, a_vld, b_vld;
  logic [SCR_DEPTH-1:0] s_eq, s_vld;

  logic        accept;
  logic        ins_a, ins_b, rot_a, rot_b, take, step_ok, step_end;
  logic [31:0] key, cur;
  logic        a_hit, b_hit, s_hit;
  logic        strobe_next;
  rsp_t        rsp_next;

  assign accept   = start && (state == ST_IDLE);
  assign busy     = (state != ST_IDLE);
  assign step_end = (step == STEP_W'(SET_DEPTH - 1));
  assign cur      = (state == ST_WALK_B) ? b_q[0] : a_q[0];
  assign key      = (state == ST_IDLE) ? req.value : cur;

  // cell chains
  for (genvar k = 0; k < SET_DEPTH; k++) begin : g_row
    logic [31:0] a_din, b_din;
    assign a_din = ins_a ? ((k == 0) ? req.value : a_q[(k == 0) ? 0 : k - 1])
                         : a_q[(k + 1) % SET_DEPTH];
    assign b_din = ins_b ? ((k == 0) ? req.value : b_q[(k == 0) ? 0 : k - 1])
                         : b_q[(k + 1) % SET_DEPTH];
    assign a_vld[k] = (CNT_W'(k) < count_a);
    assign b_vld[k] = (CNT_W'(k) < count_b);
    bsiu_cell u_a (.clk(clk), .en(ins_a || rot_a), .din(a_din), .key(key),
                   .q(a_q[k]), .eq(a_eq[k]));
    bsiu_cell u_b (.clk(clk), .en(ins_b || rot_b), .din(b_din), .key(key),
                   .q(b_q[k]), .eq(b_eq[k]));
  end

  for (genvar k = 0; k < SCR_DEPTH; k++) begin : g_scr
    logic [31:0] s_din;
    assign s_din    = (k == 0) ? cur : s_q[(k == 0) ? 0 : k - 1];
    assign s_vld[k] = (FILL_W'(k) < fill);
    bsiu_cell u_s (.clk(clk), .en(take), .din(s_din), .key(cur),
                   .q(s_q[k]), .eq(s_eq[k]));
  end

  assign a_hit = |(a_eq & a_vld);
  assign b_hit = |(b_eq & b_vld);
  assign s_hit = |(s_eq & s_vld);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept && (req.command == CMD_ISECT || req.command == CMD_UNION)) begin
          state_next = ST_WALK_A;
        end
      end
      ST_WALK_A: begin
        if (step_end) state_next = op_union ? ST_WALK_B : ST_FLUSH;
      end
      ST_WALK_B: begin
        if (step_end) state_next = ST_FLUSH;
      end
      ST_FLUSH: state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // outputs and cell controls
  always_comb begin
    ins_a       = 1'b0;
    ins_b       = 1'b0;
    rot_a       = 1'b0;
    rot_b       = 1'b0;
    step_ok     = 1'b0;
    take        = 1'b0;
    strobe_next = 1'b0;
    rsp_next    = '0;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          strobe_next   = !(req.command == CMD_ISECT || req.command == CMD_UNION);
          rsp_next.last = 1'b1;
          if (req.command == CMD_INSERT) begin
            if (req.which_set) begin
              ins_b           = (count_b != CNT_W'(SET_DEPTH));
              rsp_next.status = !ins_b;
            end else begin
              ins_a           = (count_a != CNT_W'(SET_DEPTH));
              rsp_next.status = !ins_a;
            end
          end else if (req.command == CMD_CONTAINS) begin
            rsp_next.found = req.which_set ? b_hit : a_hit;
          end
        end
      end
      ST_WALK_A: begin
        rot_a   = 1'b1;
        step_ok = (CNT_W'(step) < count_a);
        take    = step_ok && (!op_isect || b_hit) && !s_hit;
      end
      ST_WALK_B: begin
        rot_b   = 1'b1;
        step_ok = (CNT_W'(step) < count_b);
        take    = step_ok && !s_hit;
      end
      ST_FLUSH: begin
        strobe_next          = 1'b1;
        rsp_next.last        = 1'b1;
        rsp_next.has_element = pend_valid;
        rsp_next.element     = pend_valid ? pend : '0;
      end
      default: ;
    endcase
    // a newly taken value releases the one held back
    if (take && pend_valid) begin
      strobe_next          = 1'b1;
      rsp_next.has_element = 1'b1;
      rsp_next.element     = pend;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      count_a    <= '0;
      count_b    <= '0;
      step       <= '0;
      fill       <= '0;
      op_isect   <= 1'b0;
      op_union   <= 1'b0;
      pend_valid <= 1'b0;
      strobe     <= 1'b0;
    end else begin
      state  <= state_next;
      strobe <= strobe_next;
      if (ins_a) count_a <= count_a + CNT_W'(1);
      if (ins_b) count_b <= count_b + CNT_W'(1);
      if (accept && req.command == CMD_CLEAR) begin
        if (req.which_set) count_b <= '0;
        else               count_a <= '0;
      end
      if (accept) begin
        op_isect   <= (req.command == CMD_ISECT);
        op_union   <= (req.command == CMD_UNION);
        step       <= '0;
        fill       <= '0;
        pend_valid <= 1'b0;
      end else if (state == ST_WALK_A || state == ST_WALK_B) begin
        step <= step_end ? '0 : step + STEP_W'(1);
      end
      if (take) begin
        fill       <= fill + FILL_W'(1);
        pend_valid <= 1'b1;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    rsp <= rsp_next;
    if (take) pend <= cur;
  end

endmodule
